@@ rtl/rvu_pkg.sv @@
package rvu_pkg;

    // Fraction bits of every Q2.F value on the ports
    localparam int FRAC_BITS = 14;
    // Result bits of the square root (radicand is twice as wide)
    localparam int ROOT_W    = 21;
    localparam int RAD_W     = 2 * ROOT_W;

    // Incident vector and surface normal, signed Q2.14
    typedef struct packed {
        logic signed [15:0] inc_x;
        logic signed [15:0] inc_y;
        logic signed [15:0] inc_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
    } t_req;

    // Refracted vector, signed Q2.14, plus total reflection flag
    typedef struct packed {
        logic signed [15:0] refr_x;
        logic signed [15:0] refr_y;
        logic signed [15:0] refr_z;
        logic               total_reflect;
    } t_rsp;

endpackage

@@ rtl/rvu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Floor of sqrt(i_rad); a side payload travels alongside.
module rvu_sqrt #(
    parameter int ROOT_W = 21,
    parameter int PAY_W  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [PAY_W-1:0]      i_pay,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [PAY_W-1:0]      o_pay
);

    localparam int REM_W = ROOT_W + 3;

    logic                  r_vld  [ROOT_W+1];
    logic [2*ROOT_W-1:0]   r_rad  [ROOT_W+1];
    logic [REM_W-1:0]      r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]     r_root [ROOT_W+1];
    logic [PAY_W-1:0]      r_pay  [ROOT_W+1];

    // stage 0 is the input itself
    always_comb begin
        r_vld[0]  = i_valid;
        r_rad[0]  = i_rad;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_pay[0]  = i_pay;
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0]  n_rem_sh;
        logic [REM_W-1:0]  n_trial;
        logic              n_ge;

        // bring down two radicand bits, try root bit one
        always_comb begin
            n_rem_sh = {r_rem[g][REM_W-3:0], r_rad[g][2*ROOT_W-1 -: 2]};
            n_trial  = {1'b0, r_root[g], 2'b01};
            n_ge     = (n_rem_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[g+1]  <= {r_rad[g][2*ROOT_W-3:0], 2'b00};
            r_rem[g+1]  <= n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root[g+1] <= {r_root[g][ROOT_W-2:0], n_ge};
            r_pay[g+1]  <= r_pay[g];
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_pay   = r_pay[ROOT_W];

endmodule

@@ rtl/refraction_vector_unit.sv @@
// Snell refraction unit: one incident vector I and one normal N per request,
// result eta*I - (eta*d + sqrt(k))*N with d = I.N, k = 1 - eta^2 (1 - d^2).
// Request channel: i_req is taken at a rising edge with i_start high; o_busy
// is always low, so a new request may enter every cycle.
// Result channel: o_valid is high for one cycle with o_rsp; it must be taken
// then, the receiver cannot stall. total_reflect marks k <= 0 (zero vector).
// Config: i_cfg_we writes i_cfg_wdata into eta (unsigned Q2.14), change it
// only while no request is in flight.
// Throughput one per cycle. Registered stages first form d, u = 1 - d^2
// and k through the eta^2 * u multiply, then the bit-per-stage square root
// runs, and the final stages build the coefficient, the products with N and
// the rounded, saturated output.
// Reset clears all valid bits and sets eta to 1.0; requests in flight are
// dropped.
module refraction_vector_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  rvu_pkg::t_req        i_req,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    output logic                 o_valid,
    output rvu_pkg::t_rsp        o_rsp
);

    localparam int F = rvu_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [32:0] eix;
        logic signed [32:0] eiy;
        logic signed [32:0] eiz;
        logic signed [22:0] edr;
        logic               tir;
    } t_carry;

    localparam int PAY_W = $bits(t_carry);

    // configuration register
    logic [15:0] r_eta;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta <= 16'd16384;
        end else if (i_cfg_we) begin
            r_eta <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    logic signed [16:0] n_eta_s;
    assign n_eta_s = $signed({1'b0, r_eta});

    // stage 1: component products and eta^2
    logic               r1_vld;
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic signed [32:0] r1_eix, r1_eiy, r1_eiz;
    logic signed [15:0] r1_nx, r1_ny, r1_nz;
    logic        [15:0] r1_eta;
    logic        [31:0] r1_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px  <= i_req.inc_x * i_req.nrm_x;
        r1_py  <= i_req.inc_y * i_req.nrm_y;
        r1_pz  <= i_req.inc_z * i_req.nrm_z;
        r1_eix <= n_eta_s * i_req.inc_x;
        r1_eiy <= n_eta_s * i_req.inc_y;
        r1_eiz <= n_eta_s * i_req.inc_z;
        r1_nx  <= i_req.nrm_x;
        r1_ny  <= i_req.nrm_y;
        r1_nz  <= i_req.nrm_z;
        r1_eta <= r_eta;
        r1_e2  <= r_eta * r_eta;
    end

    // stage 2: dot product, rounded to d
    logic signed [34:0] n2_dot;
    assign n2_dot = 35'(r1_px) + 35'(r1_py) + 35'(r1_pz) + 35'(1 << (F - 1));

    logic               r2_vld;
    logic signed [18:0] r2_d;
    logic signed [32:0] r2_eix, r2_eiy, r2_eiz;
    logic signed [15:0] r2_nx, r2_ny, r2_nz;
    logic        [15:0] r2_eta;
    logic        [31:0] r2_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_d   <= n2_dot[F+18:F];
        r2_eix <= r1_eix;
        r2_eiy <= r1_eiy;
        r2_eiz <= r1_eiz;
        r2_nx  <= r1_nx;
        r2_ny  <= r1_ny;
        r2_nz  <= r1_nz;
        r2_eta <= r1_eta;
        r2_e2  <= r1_e2;
    end

    // stage 3: d^2 and eta*d
    logic               r3_vld;
    logic signed [37:0] r3_dd;
    logic signed [35:0] r3_ed;
    logic signed [32:0] r3_eix, r3_eiy, r3_eiz;
    logic signed [15:0] r3_nx, r3_ny, r3_nz;
    logic        [31:0] r3_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_dd  <= r2_d * r2_d;
        r3_ed  <= $signed({1'b0, r2_eta}) * r2_d;
        r3_eix <= r2_eix;
        r3_eiy <= r2_eiy;
        r3_eiz <= r2_eiz;
        r3_nx  <= r2_nx;
        r3_ny  <= r2_ny;
        r3_nz  <= r2_nz;
        r3_e2  <= r2_e2;
    end

    // stage 4: u = 1 - d^2, rounded eta*d
    logic signed [38:0] n4_u;
    logic signed [36:0] n4_ed;
    assign n4_u  = 39'(64'sd1 << (2 * F)) - 39'(r3_dd) + 39'(1 << (F - 1));
    assign n4_ed = 37'(r3_ed) + 37'(1 << (F - 1));

    logic               r4_vld;
    logic signed [24:0] r4_u;
    logic signed [22:0] r4_edr;
    logic signed [32:0] r4_eix, r4_eiy, r4_eiz;
    logic signed [15:0] r4_nx, r4_ny, r4_nz;
    logic        [31:0] r4_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_u   <= n4_u[F+24:F];
        r4_edr <= n4_ed[F+22:F];
        r4_eix <= r3_eix;
        r4_eiy <= r3_eiy;
        r4_eiz <= r3_eiz;
        r4_nx  <= r3_nx;
        r4_ny  <= r3_ny;
        r4_nz  <= r3_nz;
        r4_e2  <= r3_e2;
    end

    // stage 5: eta^2 * u
    logic               r5_vld;
    logic signed [57:0] r5_m;
    logic signed [22:0] r5_edr;
    logic signed [32:0] r5_eix, r5_eiy, r5_eiz;
    logic signed [15:0] r5_nx, r5_ny, r5_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_m   <= $signed({1'b0, r4_e2}) * r4_u;
        r5_edr <= r4_edr;
        r5_eix <= r4_eix;
        r5_eiy <= r4_eiy;
        r5_eiz <= r4_eiz;
        r5_nx  <= r4_nx;
        r5_ny  <= r4_ny;
        r5_nz  <= r4_nz;
    end

    // stage 6: k = 1 - round(eta^2 u), total reflection test, radicand
    logic signed [58:0] n6_m;
    logic signed [31:0] n6_k;
    logic               n6_tir;
    assign n6_m   = 59'(r5_m) + 59'(64'sd1 << (2 * F - 1));
    assign n6_k   = 32'(1 << F) - 32'($signed(n6_m[58:2*F]));
    assign n6_tir = n6_k[31] || (n6_k == 32'sd0);

    logic                       r6_vld;
    logic [rvu_pkg::RAD_W-1:0]  r6_rad;
    t_carry                     r6_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_rad      <= n6_tir ? '0 : {n6_k[rvu_pkg::RAD_W-F-1:0], {F{1'b0}}};
        r6_car.nx   <= r5_nx;
        r6_car.ny   <= r5_ny;
        r6_car.nz   <= r5_nz;
        r6_car.eix  <= r5_eix;
        r6_car.eiy  <= r5_eiy;
        r6_car.eiz  <= r5_eiz;
        r6_car.edr  <= r5_edr;
        r6_car.tir  <= n6_tir;
    end

    // square root of k * 2^F
    logic                        n_sq_vld;
    logic [rvu_pkg::ROOT_W-1:0]  n_sq_root;
    logic [PAY_W-1:0]            n_sq_pay;
    t_carry                      n_sq_car;

    rvu_sqrt #(
        .ROOT_W (rvu_pkg::ROOT_W),
        .PAY_W  (PAY_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_rad   (r6_rad),
        .i_pay   (r6_car),
        .o_valid (n_sq_vld),
        .o_root  (n_sq_root),
        .o_pay   (n_sq_pay)
    );

    assign n_sq_car = t_carry'(n_sq_pay);

    // coefficient c = round(eta*d) + sqrt(k)
    logic               r7_vld;
    logic signed [23:0] r7_coef;
    t_carry             r7_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= n_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_coef <= 24'(n_sq_car.edr) + $signed({3'b000, n_sq_root});
        r7_car  <= n_sq_car;
    end

    // products c * N
    logic               r8_vld;
    logic signed [39:0] r8_px, r8_py, r8_pz;
    t_carry             r8_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_px  <= r7_coef * r7_car.nx;
        r8_py  <= r7_coef * r7_car.ny;
        r8_pz  <= r7_coef * r7_car.nz;
        r8_car <= r7_car;
    end

    // difference, round, saturate
    function automatic logic signed [15:0] fin(input logic signed [32:0] ei,
                                               input logic signed [39:0] p);
        logic signed [41:0] v;
        logic signed [27:0] r;
        v = 42'(ei) - 42'(p) + 42'(1 << (rvu_pkg::FRAC_BITS - 1));
        r = v[rvu_pkg::FRAC_BITS+27:rvu_pkg::FRAC_BITS];
        if (r > 28'sd32767) begin
            return 16'sh7fff;
        end else if (r < -28'sd32768) begin
            return 16'sh8000;
        end else begin
            return r[15:0];
        end
    endfunction

    typedef rvu_pkg::t_rsp t_rsp_l;
    logic   r9_vld;
    t_rsp_l r9_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r9_rsp.refr_x        <= r8_car.tir ? 16'sd0 : fin(r8_car.eix, r8_px);
        r9_rsp.refr_y        <= r8_car.tir ? 16'sd0 : fin(r8_car.eiy, r8_py);
        r9_rsp.refr_z        <= r8_car.tir ? 16'sd0 : fin(r8_car.eiz, r8_pz);
        r9_rsp.total_reflect <= r8_car.tir;
    end

    assign o_valid = r9_vld;
    assign o_rsp   = r9_rsp;

    // total reflection always yields the zero vector
    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.total_reflect |->
            (o_rsp.refr_x == 16'sd0) && (o_rsp.refr_y == 16'sd0) &&
            (o_rsp.refr_z == 16'sd0))
        else $error("total reflection with nonzero vector");

    // a reflected item feeds a zero radicand into the root pipeline
    a_tir_rad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_vld && r6_car.tir |-> (r6_rad == '0))
        else $error("nonzero radicand on total reflection");

    // a valid result follows a coefficient through the r8 and r9 stages
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_vld |=> ##1 o_valid)
        else $error("result lost in output stages");

endmodule

@@ bench/tb_refraction_vector_unit.sv @@
module tb_refraction_vector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 5;
    localparam int PER_PHASE   = 190;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    logic          o_busy;
    rvu_pkg::t_req i_req = '0;
    logic          i_cfg_we = 1'b0;
    logic [15:0]   i_cfg_wdata = '0;
    logic          o_valid;
    rvu_pkg::t_rsp o_rsp;

    // Expected-result side channel, moves with the request
    logic          drv_typed = 1'b0;
    rvu_pkg::t_rsp drv_typed_rsp = '0;

    logic [15:0]   eta_shadow = 16'd16384;
    rvu_pkg::t_rsp refr_expected[$];
    int            err_count = 0;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;

    typedef struct {
        rvu_pkg::t_req req;
        bit            typed;
        rvu_pkg::t_rsp rsp;
    } t_dir_row;

    refraction_vector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // Round half up on an arithmetic shift
    function automatic longint round_half_up(longint v, int s);
        longint q;
        q = v >>> (s - 1);
        return (q + 1) >>> 1;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res;
        longint bitv;
        res  = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Snell refraction in Q2.14
    function automatic rvu_pkg::t_rsp refract(rvu_pkg::t_req r, logic [15:0] eta_u);
        longint        iv[3];
        longint        nv[3];
        longint        eta, dot, d, u, k, sq, coef;
        rvu_pkg::t_rsp o;
        eta = longint'(eta_u);
        iv[0] = longint'(r.inc_x); iv[1] = longint'(r.inc_y); iv[2] = longint'(r.inc_z);
        nv[0] = longint'(r.nrm_x); nv[1] = longint'(r.nrm_y); nv[2] = longint'(r.nrm_z);
        dot = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
        d = round_half_up(dot, rvu_pkg::FRAC_BITS);
        u = round_half_up((longint'(1) << (2 * rvu_pkg::FRAC_BITS)) - d * d,
                          rvu_pkg::FRAC_BITS);
        // eta^2 * u stays far inside 64 bits for 16-bit inputs
        k = (longint'(1) << rvu_pkg::FRAC_BITS) -
            round_half_up(eta * eta * u, 2 * rvu_pkg::FRAC_BITS);
        o = '0;
        if (k <= 0) begin
            o.total_reflect = 1'b1;
            return o;
        end
        sq   = floor_sqrt(k << rvu_pkg::FRAC_BITS);
        coef = round_half_up(eta * d, rvu_pkg::FRAC_BITS) + sq;
        o.refr_x = clamp16(round_half_up(eta * iv[0] - coef * nv[0], rvu_pkg::FRAC_BITS));
        o.refr_y = clamp16(round_half_up(eta * iv[1] - coef * nv[1], rvu_pkg::FRAC_BITS));
        o.refr_z = clamp16(round_half_up(eta * iv[2] - coef * nv[2], rvu_pkg::FRAC_BITS));
        return o;
    endfunction

    // Record expectation for each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            if (drv_typed) refr_expected.push_back(drv_typed_rsp);
            else refr_expected.push_back(refract(i_req, eta_shadow));
        end
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        rvu_pkg::t_rsp e;
        if (i_rst_n && o_valid) begin
            if (refr_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_rsp);
                err_count++;
            end else begin
                e = refr_expected.pop_front();
                if (o_rsp.refr_x !== e.refr_x || o_rsp.refr_y !== e.refr_y ||
                    o_rsp.refr_z !== e.refr_z ||
                    o_rsp.total_reflect !== e.total_reflect) begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d tir=%0b",
                             $time, e.refr_x, e.refr_y, e.refr_z, e.total_reflect);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d tir=%0b",
                             $time, o_rsp.refr_x, o_rsp.refr_y, o_rsp.refr_z,
                             o_rsp.total_reflect);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one request and hold it until taken; random gap afterwards
    task automatic send_request(rvu_pkg::t_req r, bit typed, rvu_pkg::t_rsp trsp);
        i_start       <= 1'b1;
        i_req         <= r;
        drv_typed     <= typed;
        drv_typed_rsp <= trsp;
        do @(posedge i_clk); while (o_busy);
        if (!no_idle && $urandom_range(99) < 8) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (refr_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_eta(logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eta_shadow  = v;
    endtask

    function automatic logic [15:0] rand_comp(bit full);
        if (full) return 16'($urandom);
        return 16'($urandom_range(32768) - 16384);
    endfunction

    function automatic rvu_pkg::t_req rand_request();
        rvu_pkg::t_req r;
        bit            full;
        full = ($urandom_range(99) < 30);
        r.inc_x = rand_comp(full); r.inc_y = rand_comp(full); r.inc_z = rand_comp(full);
        r.nrm_x = rand_comp(full); r.nrm_y = rand_comp(full); r.nrm_z = rand_comp(full);
        return r;
    endfunction

    function automatic rvu_pkg::t_req mk(int ix, int iy, int iz, int nx, int ny, int nz);
        rvu_pkg::t_req r;
        r.inc_x = 16'(ix); r.inc_y = 16'(iy); r.inc_z = 16'(iz);
        r.nrm_x = 16'(nx); r.nrm_y = 16'(ny); r.nrm_z = 16'(nz);
        return r;
    endfunction

    t_dir_row    dir_rows[$];
    logic [15:0] eta_phase[N_PHASES];

    initial begin
        rvu_pkg::t_rsp z;
        rvu_pkg::t_rsp tr;
        z = '0;

        // Directed table, eta = 1.0 after reset
        tr = '0; tr.total_reflect = 1'b1;
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, tr});
        tr = '0; tr.refr_x = -16'sd16384;
        dir_rows.push_back('{mk(16384, 0, 0, 16384, 0, 0), 1, tr});
        tr = '0; tr.refr_y = -16'sd16384;
        dir_rows.push_back('{mk(0, 16384, 0, 0, 16384, 0), 1, tr});
        dir_rows.push_back('{mk(0, 0, 16384, 0, 0, 0), 0, z});
        dir_rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768), 0, z});
        dir_rows.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767), 0, z});
        dir_rows.push_back('{mk(32767, -32768, 32767, -32768, 32767, -32768), 0, z});
        dir_rows.push_back('{mk(-32768, 0, 0, 32767, 0, 0), 0, z});
        dir_rows.push_back('{mk(11585, 11585, 0, 0, 16384, 0), 0, z});
        dir_rows.push_back('{mk(16384, 0, 0, 0, 16384, 0), 0, z});
        dir_rows.push_back('{mk(-9459, -9459, -9459, 0, 0, 16384), 0, z});
        dir_rows.push_back('{mk(1, -1, 1, -1, 1, -1), 0, z});
        dir_rows.push_back('{mk(21845, 0, -21845, 0, 32767, 0), 0, z});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) send_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp);
        drain();

        // Total reflection at high eta, directed
        write_eta(16'hFFFF);
        send_request(mk(8192, 0, 0, 0, 16384, 0), 0, z);
        send_request(mk(0, 0, 0, 0, 0, 16384), 0, z);
        drain();

        eta_phase[0] = 16'd16384;
        eta_phase[1] = 16'd0;
        eta_phase[2] = 16'($urandom_range(8192, 24576));
        eta_phase[3] = 16'hFFFF;
        eta_phase[4] = 16'($urandom);
        for (int p = 0; p < N_PHASES; p++) begin
            write_eta(eta_phase[p]);
            no_idle = (p == 2);
            for (int n = 0; n < PER_PHASE; n++) send_request(rand_request(), 0, z);
            drain();
        end
        no_idle = 1'b0;

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
